[hdl/ims_pkg.sv]
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants of the IRC line serializer: op codes, separator
// characters, escape helpers and the request format between front and back.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam logic [2:0] OP_TAG_NAME  = 3'd0;
  localparam logic [2:0] OP_TAG_VALUE = 3'd1;
  localparam logic [2:0] OP_PREFIX    = 3'd2;
  localparam logic [2:0] OP_COMMAND   = 3'd3;
  localparam logic [2:0] OP_PARAM     = 3'd4;
  localparam logic [2:0] OP_END       = 3'd5;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;

  localparam logic [15:0] LIMIT_RESET = 16'd512;

  // Up to three bytes of one input item, in output order.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            is_end;
  } entry_t;

  function automatic logic esc_needed(input logic [7:0] b);
    esc_needed = (b == CH_SEMI) || (b == CH_SPACE) || (b == CH_BSL) ||
                 (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    case (b)
      CH_SEMI:  esc_code = CH_COLON;
      CH_SPACE: esc_code = CH_S;
      CH_CR:    esc_code = CH_R;
      CH_LF:    esc_code = CH_N;
      default:  esc_code = CH_BSL;
    endcase
  endfunction

endpackage

[hdl/ims_front.sv]
// ----------------------------------------------------------------------------
// ims_front
// Accepts field items, tracks the line section and turns each item into
// a request of up to three bytes with separators and escapes in place.
// ----------------------------------------------------------------------------
module ims_front import ims_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [2:0] op,
  input  logic       field_start,
  input  logic       trailing_param,
  input  logic       has_byte,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       q_write,
  output entry_t     q_data
);

  typedef enum logic [2:0] {
    SEC_NONE, SEC_TAG, SEC_VAL, SEC_PRE, SEC_CMD, SEC_PAR
  } section_t;

  section_t section, section_next;
  logic     tags_seen, tags_seen_next;
  logic     accept;

  assign accept = push && !q_full;

  always_comb begin
    logic [1:0] cnt;
    logic [2:0] sec_rank;
    logic [2:0] op_rank;
    logic       close_sp;
    entry_t     ent;
    ent            = '0;
    cnt            = 2'd0;
    section_next   = section;
    tags_seen_next = tags_seen;
    case (section)
      SEC_NONE:         sec_rank = 3'd0;
      SEC_TAG, SEC_VAL: sec_rank = 3'd1;
      default:          sec_rank = 3'(section) - 3'd1;
    endcase
    op_rank  = (op == OP_TAG_NAME) ? 3'd1 : op;
    close_sp = (section == SEC_TAG) || (section == SEC_VAL) || (section == SEC_PRE);

    if (op == OP_END) begin
      ent.is_end = 1'b1;
      if (close_sp) begin
        ent.data[cnt] = CH_SPACE;
        cnt = cnt + 2'd1;
      end
      ent.data[cnt] = CH_CR;
      cnt = cnt + 2'd1;
      ent.data[cnt] = CH_LF;
      cnt = cnt + 2'd1;
      section_next   = SEC_NONE;
      tags_seen_next = 1'b0;
    end else if (op <= OP_PARAM && op_rank >= sec_rank) begin
      case (op)
        OP_TAG_NAME: begin
          if (field_start || section != SEC_TAG) begin
            ent.data[cnt] = tags_seen ? CH_SEMI : CH_AT;
            cnt = cnt + 2'd1;
            tags_seen_next = 1'b1;
            section_next   = SEC_TAG;
          end
          if (has_byte) begin
            ent.data[cnt] = data_byte;
            cnt = cnt + 2'd1;
          end
        end
        OP_TAG_VALUE: begin
          if ((section == SEC_TAG || section == SEC_VAL) && has_byte) begin
            if (section == SEC_TAG) begin
              ent.data[cnt] = CH_EQ;
              cnt = cnt + 2'd1;
              section_next = SEC_VAL;
            end
            if (esc_needed(data_byte)) begin
              ent.data[cnt] = CH_BSL;
              cnt = cnt + 2'd1;
              ent.data[cnt] = esc_code(data_byte);
              cnt = cnt + 2'd1;
            end else begin
              ent.data[cnt] = data_byte;
              cnt = cnt + 2'd1;
            end
          end
        end
        OP_PREFIX: begin
          if (section != SEC_PRE) begin
            if (close_sp) begin
              ent.data[cnt] = CH_SPACE;
              cnt = cnt + 2'd1;
            end
            ent.data[cnt] = CH_COLON;
            cnt = cnt + 2'd1;
            section_next = SEC_PRE;
          end
          if (has_byte) begin
            ent.data[cnt] = data_byte;
            cnt = cnt + 2'd1;
          end
        end
        OP_COMMAND: begin
          if (section != SEC_CMD) begin
            if (close_sp) begin
              ent.data[cnt] = CH_SPACE;
              cnt = cnt + 2'd1;
            end
            section_next = SEC_CMD;
          end
          if (has_byte) begin
            ent.data[cnt] = data_byte;
            cnt = cnt + 2'd1;
          end
        end
        default: begin
          if (field_start || section != SEC_PAR) begin
            ent.data[cnt] = CH_SPACE;
            cnt = cnt + 2'd1;
            if (trailing_param) begin
              ent.data[cnt] = CH_COLON;
              cnt = cnt + 2'd1;
            end
            section_next = SEC_PAR;
          end
          if (has_byte) begin
            ent.data[cnt] = data_byte;
            cnt = cnt + 2'd1;
          end
        end
      endcase
    end
    ent.cnt = cnt;
    q_data  = ent;
    q_write = accept && (ent.is_end || cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section   <= SEC_NONE;
      tags_seen <= 1'b0;
    end else if (accept) begin
      section   <= section_next;
      tags_seen <= tags_seen_next;
    end
  end

endmodule

[hdl/ims_queue.sv]
// ----------------------------------------------------------------------------
// ims_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module ims_queue import ims_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd,
  output logic   head_valid,
  output entry_t head
);

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ims_back.sv]
// ----------------------------------------------------------------------------
// ims_back
// Writes request bytes one per cycle, unless an output byte waits unpopped,
// against the buffer limit, counts the needed length and closes the line with
// the last, truncated and length fields. Holds the output and limit registers.
// ----------------------------------------------------------------------------
module ims_back import ims_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        q_read,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        truncated,
  output logic [15:0] needed_length
);

  logic [15:0] limit;
  logic [15:0] written;
  logic [15:0] needed;
  logic        cut;
  logic [1:0]  idx;
  logic        out_valid;

  logic        step;
  logic [7:0]  cur;
  logic        can_write;
  logic        final_w;
  logic [1:0]  remain;
  logic [15:0] needed_inc;
  logic [16:0] needed_sum;
  logic [15:0] needed_fin;
  logic        entry_done;

  assign empty      = !out_valid;
  assign step       = head_valid && (!out_valid || pop);
  assign cur        = head.data[idx];
  assign can_write  = written < limit;
  assign final_w    = (idx == head.cnt - 2'd1) ||
                      (({1'b0, written} + 17'd1) >= {1'b0, limit});
  assign remain     = head.cnt - idx;
  assign needed_inc = (needed == 16'hFFFF) ? needed : needed + 16'd1;
  assign needed_sum = {1'b0, needed} + {15'd0, remain};
  assign needed_fin = needed_sum[16] ? 16'hFFFF : needed_sum[15:0];
  assign entry_done = (head.is_end && (final_w || !can_write)) ||
                      (idx == head.cnt - 2'd1);
  assign q_read     = step && entry_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= 16'd0;
      needed    <= 16'd0;
      cut       <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        idx <= entry_done ? 2'd0 : idx + 2'd1;
        if (head.is_end && (final_w || !can_write)) begin
          out_valid     <= 1'b1;
          out_byte      <= can_write ? cur : 8'd0;
          last          <= 1'b1;
          truncated     <= cut || (remain != 2'd1) || !can_write;
          needed_length <= needed_fin;
          written       <= 16'd0;
          needed        <= 16'd0;
          cut           <= 1'b0;
        end else begin
          needed <= needed_inc;
          if (can_write) begin
            out_valid     <= 1'b1;
            out_byte      <= cur;
            last          <= 1'b0;
            truncated     <= cut;
            needed_length <= 16'd0;
            written       <= written + 16'd1;
          end else begin
            cut <= 1'b1;
          end
        end
      end
    end
  end

endmodule

[hdl/irc_message_serializer.sv]
// ----------------------------------------------------------------------------
// irc_message_serializer
// Builds one IRC line with IRCv3 tag escaping from a stream of field items.
//
// Input queue side: an item is taken when push is high and full is low.
// Result queue side: the oldest byte sits on out_byte/last/truncated/
// needed_length while empty is low and is taken when pop is high.
// Config: cfg_write loads cfg_data into the buffer limit (reset 512); write
// only between lines with the block drained.
// Each item becomes up to three bytes (separators, escapes, CR LF); the back
// end writes one byte per cycle while the result register is free or being
// popped. An accepted item passes through the request queue and the output
// register before empty falls. A two-entry request queue lets the front take
// items while the back is still busy. When pop is held low the result
// register holds and the back stalls; once the queue fills, full rises. Reset
// empties both sides, clears the line state and sets the limit to 512.
// ----------------------------------------------------------------------------
module irc_message_serializer import ims_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic        field_start,
  input  logic        trailing_param,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        truncated,
  output logic [15:0] needed_length,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic   q_write;
  entry_t q_data;
  logic   q_read;
  logic   head_valid;
  entry_t head;

  ims_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .op             (op),
    .field_start    (field_start),
    .trailing_param (trailing_param),
    .has_byte       (has_byte),
    .data_byte      (data_byte),
    .q_full         (full),
    .q_write        (q_write),
    .q_data         (q_data)
  );

  ims_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_write),
    .wr_data    (q_data),
    .full       (full),
    .rd         (q_read),
    .head_valid (head_valid),
    .head       (head)
  );

  ims_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .head_valid    (head_valid),
    .head          (head),
    .q_read        (q_read),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .last          (last),
    .truncated     (truncated),
    .needed_length (needed_length)
  );

endmodule

[dv/irc_line_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_checker
// Watches the item and byte queues of the IRC line serializer. It keeps its
// own copy of the line state and buffer limit, works out the bytes that each
// accepted request must produce, and compares every popped byte, field by
// field, with the oldest expected one. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module irc_line_checker import ims_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  op,
  input  logic        field_start,
  input  logic        trailing_param,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last,
  input  logic        truncated,
  input  logic [15:0] needed_length,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    SEC_NONE      = 3'd0,
    SEC_TAG_NAME  = 3'd1,
    SEC_TAG_VALUE = 3'd2,
    SEC_PREFIX    = 3'd3,
    SEC_COMMAND   = 3'd4,
    SEC_PARAM     = 3'd5
  } section_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        truncated;
    logic [15:0] length;
  } line_byte_t;

  line_byte_t expected_bytes[$];
  line_byte_t item_bytes[$];

  section_t    sect;
  logic        tags_open;
  logic [16:0] wr_count;
  logic [15:0] need_count;
  logic        cut;
  logic [15:0] limit;
  int          errors = 0;

  initial fail_count = 0;
  initial pending = 0;

  task automatic clear_line();
    sect       = SEC_NONE;
    tags_open  = 1'b0;
    wr_count   = '0;
    need_count = '0;
    cut        = 1'b0;
  endtask

  function automatic logic [2:0] level_of(input section_t s);
    if (s == SEC_NONE) return 3'd0;
    if (s <= SEC_TAG_VALUE) return 3'd1;
    return 3'(s) - 3'd1;
  endfunction

  function automatic logic closing_space_due();
    return sect == SEC_TAG_NAME || sect == SEC_TAG_VALUE || sect == SEC_PREFIX;
  endfunction

  // Every byte counts toward the needed length; only those under the limit
  // are written.
  task automatic put_byte(input logic [7:0] b);
    line_byte_t r;
    if (need_count != 16'hFFFF) need_count = need_count + 16'd1;
    if (wr_count < {1'b0, limit}) begin
      r.data      = b;
      r.last      = 1'b0;
      r.truncated = cut;
      r.length    = '0;
      item_bytes.push_back(r);
      wr_count = wr_count + 17'd1;
    end else begin
      cut = 1'b1;
    end
  endtask

  task automatic put_value_byte(input logic [7:0] b);
    case (b)
      CH_SEMI: begin
        put_byte(CH_BSL);
        put_byte(CH_COLON);
      end
      CH_SPACE: begin
        put_byte(CH_BSL);
        put_byte(CH_S);
      end
      CH_BSL: begin
        put_byte(CH_BSL);
        put_byte(CH_BSL);
      end
      CH_CR: begin
        put_byte(CH_BSL);
        put_byte(CH_R);
      end
      CH_LF: begin
        put_byte(CH_BSL);
        put_byte(CH_N);
      end
      default: put_byte(b);
    endcase
  endtask

  task automatic serialize_request(input logic [2:0] o, input logic fs, input logic tr,
                                   input logic hb, input logic [7:0] b);
    line_byte_t r;
    logic [2:0] rank;
    item_bytes.delete();
    if (o == OP_END) begin
      if (closing_space_due()) put_byte(CH_SPACE);
      put_byte(CH_CR);
      put_byte(CH_LF);
      if (item_bytes.size() == 0) begin
        r = '0;
        item_bytes.push_back(r);
      end
      r = item_bytes[item_bytes.size() - 1];
      r.last      = 1'b1;
      r.truncated = cut;
      r.length    = need_count;
      item_bytes[item_bytes.size() - 1] = r;
      clear_line();
    end else if (o < OP_END) begin
      rank = (o == OP_TAG_NAME) ? 3'd1 : o;
      if (rank >= level_of(sect)) begin
        case (o)
          OP_TAG_NAME: begin
            if (fs || sect != SEC_TAG_NAME) begin
              put_byte(tags_open ? CH_SEMI : CH_AT);
              tags_open = 1'b1;
              sect = SEC_TAG_NAME;
            end
            if (hb) put_byte(b);
          end
          OP_TAG_VALUE: begin
            if (sect == SEC_TAG_NAME) begin
              if (hb) begin
                put_byte(CH_EQ);
                sect = SEC_TAG_VALUE;
                put_value_byte(b);
              end
            end else if (sect == SEC_TAG_VALUE) begin
              if (hb) put_value_byte(b);
            end
          end
          OP_PREFIX: begin
            if (sect != SEC_PREFIX) begin
              if (closing_space_due()) put_byte(CH_SPACE);
              put_byte(CH_COLON);
              sect = SEC_PREFIX;
            end
            if (hb) put_byte(b);
          end
          OP_COMMAND: begin
            if (sect != SEC_COMMAND) begin
              if (closing_space_due()) put_byte(CH_SPACE);
              sect = SEC_COMMAND;
            end
            if (hb) put_byte(b);
          end
          OP_PARAM: begin
            if (fs || sect != SEC_PARAM) begin
              put_byte(CH_SPACE);
              if (tr) put_byte(CH_COLON);
              sect = SEC_PARAM;
            end
            if (hb) put_byte(b);
          end
          default: ;
        endcase
      end
    end
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endtask

  task automatic check_byte();
    line_byte_t e;
    if (expected_bytes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected byte %02h last %0b trunc %0b len %0d", $realtime,
                 out_byte, last, truncated, needed_length);
    end else begin
      e = expected_bytes.pop_front();
      if (out_byte !== e.data || last !== e.last || truncated !== e.truncated ||
          needed_length !== e.length) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d", $realtime,
                   e.data, e.last, e.truncated, e.length,
                   out_byte, last, truncated, needed_length);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit = LIMIT_RESET;
      clear_line();
      expected_bytes.delete();
    end else begin
      if (!empty && pop) check_byte();
      if (cfg_write) limit = cfg_data;
      if (push && !full)
        serialize_request(op, field_start, trailing_param, has_byte, data_byte);
    end
    fail_count = errors;
    pending    = expected_bytes.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the IRC line serializer: directed lines for separators,
// escapes, ordering rules and truncation, then random well-formed lines with
// some noise under several buffer limits and idle patterns. The checker
// predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ims_pkg::*;

  localparam int MAX_CYCLES = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  op = OP_END;
  logic        field_start = 1'b0;
  logic        trailing_param = 1'b0;
  logic        has_byte = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last;
  logic        truncated;
  logic [15:0] needed_length;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 17;
  int pop_idle_pct = 47;
  int items_sent = 0;
  int cycles = 0;

  irc_message_serializer dut (
    .clk, .rst, .push, .full, .op, .field_start, .trailing_param, .has_byte,
    .data_byte, .empty, .pop, .out_byte, .last, .truncated, .needed_length,
    .cfg_write, .cfg_data
  );

  irc_line_checker u_checker (
    .clk, .rst, .push, .full, .op, .field_start, .trailing_param, .has_byte,
    .data_byte, .empty, .pop, .out_byte, .last, .truncated, .needed_length,
    .cfg_write, .cfg_data, .fail_count, .pending
  );

  always #5 clk = ~clk;

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request
  // is taken.
  task automatic send(input logic [2:0] o, input logic fs, input logic tr,
                      input logic hb, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push           <= 1'b1;
    op             <= o;
    field_start    <= fs;
    trailing_param <= tr;
    has_byte       <= hb;
    data_byte      <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (o <= OP_END) items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[5];
    specials = '{CH_SEMI, CH_SPACE, CH_BSL, CH_CR, CH_LF};
    if ($urandom_range(99) < 40) return specials[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_noise();
    send(3'($urandom_range(7)), 1'($urandom), 1'($urandom), 1'($urandom), pick_byte());
  endtask

  task automatic send_field(input logic [2:0] o, input int len);
    send(o, $urandom_range(7) != 0, 1'($urandom), len > 0, pick_byte());
    for (int i = 1; i < len; i++)
      send(o, 1'b0, 1'($urandom), $urandom_range(9) != 0, pick_byte());
    if ($urandom_range(19) == 0) send_noise();
  endtask

  task automatic send_random_line();
    int n_tags;
    int n_params;
    n_tags   = $urandom_range(0, 3);
    n_params = $urandom_range(0, 3);
    for (int t = 0; t < n_tags; t++) begin
      send_field(OP_TAG_NAME, $urandom_range(0, 4));
      if ($urandom_range(1)) send_field(OP_TAG_VALUE, $urandom_range(0, 5));
    end
    if ($urandom_range(2) == 0) send_field(OP_PREFIX, $urandom_range(1, 6));
    if ($urandom_range(4) != 0) send_field(OP_COMMAND, $urandom_range(1, 5));
    for (int p = 0; p < n_params; p++) send_field(OP_PARAM, $urandom_range(0, 5));
    send(OP_END, 1'($urandom), 1'($urandom), 1'($urandom), pick_byte());
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit: separators, escapes, ordering rules
    send(OP_TAG_VALUE, 1'b1, 1'b0, 1'b1, "v");
    send(OP_TAG_NAME,  1'b1, 1'b0, 1'b1, "a");
    send(OP_TAG_NAME,  1'b0, 1'b0, 1'b1, "b");
    send(OP_TAG_VALUE, 1'b1, 1'b0, 1'b0, 8'h00);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_SEMI);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_SPACE);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_BSL);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_CR);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_LF);
    send(OP_TAG_NAME,  1'b1, 1'b0, 1'b0, 8'h00);
    send(OP_PREFIX,    1'b1, 1'b1, 1'b1, 8'hFF);
    send(OP_PREFIX,    1'b1, 1'b0, 1'b1, 8'h00);
    send(OP_TAG_NAME,  1'b1, 1'b0, 1'b1, "x");
    send(OP_COMMAND,   1'b1, 1'b0, 1'b0, 8'h00);
    send(OP_COMMAND,   1'b1, 1'b0, 1'b1, "P");
    send(OP_PARAM,     1'b1, 1'b0, 1'b1, "#");
    send(OP_PARAM,     1'b1, 1'b1, 1'b1, 8'h80);
    send(3'd6,         1'b1, 1'b1, 1'b1, 8'h55);
    send(3'd7,         1'b0, 1'b0, 1'b0, 8'hAA);
    send(OP_END,       1'b0, 1'b0, 1'b0, 8'h00);
    // parameter straight after tags, opened by a continuation
    send(OP_TAG_NAME,  1'b1, 1'b0, 1'b1, "k");
    send(OP_PARAM,     1'b0, 1'b1, 1'b1, "z");
    send(OP_END,       1'b1, 1'b1, 1'b1, 8'hFF);
    send(OP_PREFIX,    1'b0, 1'b0, 1'b1, "p");
    send(OP_END,       1'b0, 1'b0, 1'b0, 8'h00);

    // nothing can be written
    set_limit(16'd0);
    send(OP_COMMAND, 1'b1, 1'b0, 1'b1, "A");
    send(OP_END,     1'b0, 1'b0, 1'b0, 8'h00);
    set_limit(16'd1);
    send(OP_END,     1'b0, 1'b0, 1'b0, 8'h00);
    // cut at the closing space, right after an escape sequence
    set_limit(16'd7);
    send(OP_TAG_NAME,  1'b1, 1'b0, 1'b1, "a");
    send(OP_TAG_VALUE, 1'b1, 1'b0, 1'b1, CH_SEMI);
    send(OP_TAG_VALUE, 1'b0, 1'b0, 1'b1, CH_SPACE);
    send(OP_END,       1'b0, 1'b0, 1'b0, 8'h00);

    set_limit(16'($urandom_range(8, 60)));
    items_sent = 0;
    while (items_sent < 120) send_random_line();

    set_limit(16'hFFFF);
    send_idle_pct = 47;
    pop_idle_pct  = 17;
    while (items_sent < 240) send_random_line();

    set_limit(16'($urandom_range(0, 80)));
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    while (items_sent < 360) send_random_line();

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[irc_message_serializer.f]
hdl/ims_pkg.sv
hdl/ims_front.sv
hdl/ims_queue.sv
hdl/ims_back.sv
hdl/irc_message_serializer.sv
dv/irc_line_checker.sv
dv/tb.sv
